[rtl/interval_arithmetic_unit_top_defines.svh]
// ----------------------------------------------------------------------------
// Interval arithmetic unit assertion macros
// Shared assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define INTERVAL_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// checked only while out of reset
`define IAU_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("interval unit check failed");

// checked through reset too
`define IAU_ASSERT_RST(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("interval unit reset check failed");

`endif

[rtl/iau_pkg.sv]
// ----------------------------------------------------------------------------
// Interval arithmetic unit package
// Opcodes, interval and queue word types, constants and helpers.
// ----------------------------------------------------------------------------
package iau_pkg;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_AND    = 4'd3,
        OP_OR     = 4'd4,
        OP_XOR    = 4'd5,
        OP_SHL    = 4'd6,
        OP_LSHR   = 4'd7,
        OP_ASHR   = 4'd8,
        OP_ZEXT   = 4'd9,
        OP_SEXT   = 4'd10,
        OP_TRUNC  = 4'd11,
        OP_SELECT = 4'd12
    } iau_op_t;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        emp;
    } ival_t;

    // one queue word: decoded operation plus operands and early flags
    typedef struct packed {
        iau_op_t op;
        ival_t   a;
        ival_t   b;
        ival_t   c;
        logic    res_empty;
        logic    a_const;
        logic    b_const;
    } iau_item_t;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] U32_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] S32_MIN = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] S32_MAX = 64'h0000_0000_7FFF_FFFF;

    localparam int IAU_QUEUE_DEPTH = 2;

    // all-ones mask up to the highest set bit, saturated to S64_MAX
    function automatic logic [63:0] pow2_bound(input logic [63:0] m);
        logic [63:0] y;
        y = m;
        y = y | (y >> 1);
        y = y | (y >> 2);
        y = y | (y >> 4);
        y = y | (y >> 8);
        y = y | (y >> 16);
        y = y | (y >> 32);
        return y[63] ? S64_MAX : y;
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

endpackage

[rtl/iau_front.sv]
// ----------------------------------------------------------------------------
// Interval unit front end
// Accepts input words, decodes the opcode and flags empty results early.
// ----------------------------------------------------------------------------
module iau_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         action,
    input  logic [63:0]        a_low,
    input  logic [63:0]        a_high,
    input  logic               a_empty,
    input  logic [63:0]        b_low,
    input  logic [63:0]        b_high,
    input  logic               b_empty,
    input  logic [63:0]        c_low,
    input  logic [63:0]        c_high,
    input  logic               c_empty,
    input  logic               q_full,
    output logic               push,
    output iau_pkg::iau_item_t push_item
);
    import iau_pkg::*;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.op      = iau_op_t'(action);
        push_item.a       = '{lo: a_low, hi: a_high, emp: a_empty};
        push_item.b       = '{lo: b_low, hi: b_high, emp: b_empty};
        push_item.c       = '{lo: c_low, hi: c_high, emp: c_empty};
        push_item.a_const = (a_low == a_high);
        push_item.b_const = (b_low == b_high);
        if (action inside {[OP_ADD:OP_ASHR]})
        begin
            push_item.res_empty = a_empty || b_empty;
        end
        else if (action inside {[OP_ZEXT:OP_TRUNC]})
        begin
            push_item.res_empty = a_empty;
        end
        else if (action == OP_SELECT)
        begin
            push_item.res_empty = a_empty || b_empty || c_empty;
        end
        else
        begin
            push_item.res_empty = 1'b0;
        end
    end

endmodule

[rtl/iau_queue.sv]
// ----------------------------------------------------------------------------
// Interval unit decoupling queue
// Small FIFO between front end and execution back end.
// ----------------------------------------------------------------------------
module iau_queue #(
    parameter int DEPTH = iau_pkg::IAU_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  iau_pkg::iau_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output iau_pkg::iau_item_t head_item
);
    import iau_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    iau_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/iau_back.sv]
// ----------------------------------------------------------------------------
// Interval unit execution back end
// Three-stage pipeline: partial products and direct ops, corner products,
// min/max merge into the output register.
// ----------------------------------------------------------------------------
module iau_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  iau_pkg::iau_item_t head_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        res_low,
    output logic [63:0]        res_high,
    output logic               res_empty
);
    import iau_pkg::*;

    logic adv;

    // stage 1
    logic        s1_valid_reg;
    logic        s1_mul_reg, mul_next;
    ival_t       s1_dir_reg, dir_next;
    logic [63:0] s1_pp_reg [4][4];
    logic [63:0] pp_next [4][4];
    logic        s1_neg_reg [4];
    logic        neg_next [4];
    logic [63:0] cx [4];
    logic [63:0] cy [4];

    // stage 2
    logic        s2_valid_reg;
    logic        s2_mul_reg;
    ival_t       s2_dir_reg;
    logic [63:0] s2_val_reg [4];
    logic        s2_ovf_reg [4];
    logic [63:0] val_next [4];
    logic        ovf_next [4];

    // output
    logic        out_valid_reg;
    ival_t       out_reg, out_next;

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = head_valid && adv;
    assign out_valid = out_valid_reg;
    assign res_low   = out_reg.lo;
    assign res_high  = out_reg.hi;
    assign res_empty = out_reg.emp;

    // direct operations and corner operand selection
    always_comb
    begin
        logic signed [63:0] al, ah, bl, bh, cl, ch, lo, hi, sa, sb, m;
        logic               oa, ob;
        logic [63:0]        f;
        al = head_item.a.lo;
        ah = head_item.a.hi;
        bl = head_item.b.lo;
        bh = head_item.b.hi;
        cl = head_item.c.lo;
        ch = head_item.c.hi;
        f  = 64'd1 << bl[5:0];
        mul_next = 1'b0;
        dir_next = '{lo: S64_MIN, hi: S64_MAX, emp: 1'b0};
        sa = '0;
        sb = '0;
        oa = 1'b0;
        ob = 1'b0;
        lo = '0;
        hi = '0;
        m  = '0;
        cx[0] = head_item.a.lo;
        cx[1] = head_item.a.lo;
        cx[2] = head_item.a.hi;
        cx[3] = head_item.a.hi;
        cy[0] = head_item.b.lo;
        cy[1] = head_item.b.hi;
        cy[2] = head_item.b.lo;
        cy[3] = head_item.b.hi;
        case (head_item.op)
            OP_ADD:
            begin
                sa = al + bl;
                sb = ah + bh;
                oa = (al[63] == bl[63]) && (sa[63] != al[63]);
                ob = (ah[63] == bh[63]) && (sb[63] != ah[63]);
                if (!oa && !ob)
                begin
                    dir_next = '{lo: sa, hi: sb, emp: 1'b0};
                end
            end
            OP_SUB:
            begin
                sa = al - bh;
                sb = ah - bl;
                oa = (al[63] != bh[63]) && (sa[63] != al[63]);
                ob = (ah[63] != bl[63]) && (sb[63] != ah[63]);
                if (!oa && !ob)
                begin
                    dir_next = '{lo: sa, hi: sb, emp: 1'b0};
                end
            end
            OP_MUL:
            begin
                mul_next = 1'b1;
            end
            OP_AND:
            begin
                if (head_item.a_const && head_item.b_const)
                begin
                    dir_next = '{lo: al & bl, hi: al & bl, emp: 1'b0};
                end
                else if (!al[63] && !bl[63])
                begin
                    dir_next = '{lo: '0, hi: (ah < bh) ? ah : bh, emp: 1'b0};
                end
                else if (!al[63])
                begin
                    dir_next = '{lo: '0, hi: ah, emp: 1'b0};
                end
                else if (!bl[63])
                begin
                    dir_next = '{lo: '0, hi: bh, emp: 1'b0};
                end
            end
            OP_OR, OP_XOR:
            begin
                if (head_item.a_const && head_item.b_const)
                begin
                    m = (head_item.op == OP_OR) ? (al | bl) : (al ^ bl);
                    dir_next = '{lo: m, hi: m, emp: 1'b0};
                end
                else if (!al[63] && !bl[63])
                begin
                    m = ah | bh;
                    if (m == '0)
                    begin
                        dir_next = '{lo: '0, hi: '0, emp: 1'b0};
                    end
                    else
                    begin
                        lo = (head_item.op == OP_OR) ? ((al > bl) ? al : bl) : '0;
                        dir_next = '{lo: lo, hi: pow2_bound(m), emp: 1'b0};
                    end
                end
            end
            OP_SHL:
            begin
                cy[0] = f;
                cy[1] = f;
                cy[2] = f;
                cy[3] = f;
                if (head_item.b_const && !bl[63] && (bl < 64'sd63))
                begin
                    mul_next = 1'b1;
                end
            end
            OP_LSHR:
            begin
                if (head_item.b_const && !bl[63] && (bl <= 64'sd64))
                begin
                    if (bl == 64'sd64)
                    begin
                        dir_next = '{lo: '0, hi: '0, emp: 1'b0};
                    end
                    else if (!al[63])
                    begin
                        dir_next = '{lo: al >>> bl[5:0], hi: ah >>> bl[5:0], emp: 1'b0};
                    end
                end
            end
            OP_ASHR:
            begin
                if (head_item.b_const && !bl[63] && (bl < 64'sd64))
                begin
                    dir_next = '{lo: al >>> bl[5:0], hi: ah >>> bl[5:0], emp: 1'b0};
                end
            end
            OP_ZEXT:
            begin
                if (!al[63] && (ah <= $signed(U32_MAX)))
                begin
                    dir_next = '{lo: al, hi: ah, emp: 1'b0};
                end
                else
                begin
                    dir_next = '{lo: '0, hi: U32_MAX, emp: 1'b0};
                end
            end
            OP_SEXT:
            begin
                lo = (al > $signed(S32_MIN)) ? al : $signed(S32_MIN);
                hi = (ah < $signed(S32_MAX)) ? ah : $signed(S32_MAX);
                if (lo > hi)
                begin
                    dir_next = '{lo: S32_MIN, hi: S32_MAX, emp: 1'b0};
                end
                else
                begin
                    dir_next = '{lo: lo, hi: hi, emp: 1'b0};
                end
            end
            OP_TRUNC:
            begin
                if ((al >= $signed(S32_MIN)) && (ah <= $signed(S32_MAX)))
                begin
                    dir_next = '{lo: al, hi: ah, emp: 1'b0};
                end
                else
                begin
                    dir_next = '{lo: S32_MIN, hi: S32_MAX, emp: 1'b0};
                end
            end
            OP_SELECT:
            begin
                if (head_item.a_const)
                begin
                    dir_next = (al != '0) ? head_item.b : head_item.c;
                end
                else
                begin
                    dir_next = '{lo: (bl < cl) ? bl : cl, hi: (bh > ch) ? bh : ch,
                                 emp: 1'b0};
                end
            end
            default:
            begin
                dir_next = '{lo: S64_MIN, hi: S64_MAX, emp: 1'b0};
            end
        endcase
        if (head_item.res_empty)
        begin
            dir_next = '{lo: '0, hi: '0, emp: 1'b1};
            mul_next = 1'b0;
        end
    end

    // 32x32 partial products of the four corner magnitudes
    always_comb
    begin
        logic [63:0] u, v;
        for (int i = 0; i < 4; i++)
        begin
            u = mag(cx[i]);
            v = mag(cy[i]);
            neg_next[i]   = cx[i][63] != cy[i][63];
            pp_next[i][0] = u[31:0]  * v[31:0];
            pp_next[i][1] = u[31:0]  * v[63:32];
            pp_next[i][2] = u[63:32] * v[31:0];
            pp_next[i][3] = u[63:32] * v[63:32];
        end
    end

    // corner product assembly and overflow
    always_comb
    begin
        logic [127:0] p;
        for (int i = 0; i < 4; i++)
        begin
            p = {64'd0, s1_pp_reg[i][0]}
                + {32'd0, s1_pp_reg[i][1], 32'd0}
                + {32'd0, s1_pp_reg[i][2], 32'd0}
                + {s1_pp_reg[i][3], 64'd0};
            if (s1_neg_reg[i])
            begin
                ovf_next[i] = (|p[127:64]) || (p[63] && (|p[62:0]));
                val_next[i] = 64'd0 - p[63:0];
            end
            else
            begin
                ovf_next[i] = (|p[127:64]) || p[63];
                val_next[i] = p[63:0];
            end
        end
    end

    // min/max merge
    always_comb
    begin
        logic signed [63:0] v0, v1, v2, v3, mn01, mn23, mx01, mx23;
        v0 = s2_val_reg[0];
        v1 = s2_val_reg[1];
        v2 = s2_val_reg[2];
        v3 = s2_val_reg[3];
        mn01 = (v0 < v1) ? v0 : v1;
        mn23 = (v2 < v3) ? v2 : v3;
        mx01 = (v0 > v1) ? v0 : v1;
        mx23 = (v2 > v3) ? v2 : v3;
        if (!s2_mul_reg)
        begin
            out_next = s2_dir_reg;
        end
        else if (s2_ovf_reg[0] || s2_ovf_reg[1] || s2_ovf_reg[2] || s2_ovf_reg[3])
        begin
            out_next = '{lo: S64_MIN, hi: S64_MAX, emp: 1'b0};
        end
        else
        begin
            out_next = '{lo: (mn01 < mn23) ? mn01 : mn23,
                         hi: (mx01 > mx23) ? mx01 : mx23, emp: 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mul_reg <= mul_next;
            s1_dir_reg <= dir_next;
            s1_pp_reg  <= pp_next;
            s1_neg_reg <= neg_next;
            s2_mul_reg <= s1_mul_reg;
            s2_dir_reg <= s1_dir_reg;
            s2_val_reg <= val_next;
            s2_ovf_reg <= ovf_next;
            out_reg    <= out_next;
        end
    end

endmodule

[rtl/interval_arithmetic_unit_top.sv]
// Path: an accepted word passes the queue, product stage, corner stage and output
//   register, in that order, before it appears on the output.
// Throughput: one word per cycle unless the output stalls; pipelined back end.
// Reset: rst_n is asynchronous, active low; it empties the queue and all valids.
// ----------------------------------------------------------------------------
// Interval arithmetic unit top level
// Signed 64-bit interval arithmetic with a decoupled front end and back end.
// ----------------------------------------------------------------------------
module interval_arithmetic_unit_top #(
    parameter int QUEUE_DEPTH = iau_pkg::IAU_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  action,
    input  logic [63:0] a_low,
    input  logic [63:0] a_high,
    input  logic        a_empty,
    input  logic [63:0] b_low,
    input  logic [63:0] b_high,
    input  logic        b_empty,
    input  logic [63:0] c_low,
    input  logic [63:0] c_high,
    input  logic        c_empty,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] res_low,
    output logic [63:0] res_high,
    output logic        res_empty
);
    import iau_pkg::*;

    // front end to queue
    logic      push;
    iau_item_t push_item;
    logic      q_full;

    // queue to back end
    logic      pop;
    logic      head_valid;
    iau_item_t head_item;

    // Front end: decodes the opcode, flags operand emptiness and constant
    // operands; ready only depends on queue occupancy.
    iau_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .a_low     (a_low),
        .a_high    (a_high),
        .a_empty   (a_empty),
        .b_low     (b_low),
        .b_high    (b_high),
        .b_empty   (b_empty),
        .c_low     (c_low),
        .c_high    (c_high),
        .c_empty   (c_empty),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // Queue: lets the front end keep taking words while the output stalls.
    iau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back end: the whole pipeline advances whenever the output register
    // is free or being drained.
    iau_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res_low    (res_low),
        .res_high   (res_high),
        .res_empty  (res_empty)
    );

endmodule

[rtl/iau_checker.sv]
// ----------------------------------------------------------------------------
// Interval unit port checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "interval_arithmetic_unit_top_defines.svh"

module iau_port_props (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] res_low,
    input logic [63:0] res_high,
    input logic        res_empty
);

    // a stalled result stays put
    `IAU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(res_low) && $stable(res_high) && $stable(res_empty))

    // an empty result carries zero bounds
    `IAU_ASSERT(a_empty_zero, out_valid && res_empty |-> res_low == 64'd0 && res_high == 64'd0)

    // nothing comes out right after reset
    `IAU_ASSERT_RST(a_reset_quiet, $rose(rst_n) |-> !out_valid)

endmodule

bind interval_arithmetic_unit_top iau_port_props u_iau_port_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_low   (res_low),
    .res_high  (res_high),
    .res_empty (res_empty)
);

[sim/iau_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interval arithmetic unit checker
// Watches both channels, predicts each result interval and compares in order.
// ----------------------------------------------------------------------------
module iau_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  action,
    input  logic [63:0] a_low,
    input  logic [63:0] a_high,
    input  logic        a_empty,
    input  logic [63:0] b_low,
    input  logic [63:0] b_high,
    input  logic        b_empty,
    input  logic [63:0] c_low,
    input  logic [63:0] c_high,
    input  logic        c_empty,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] res_low,
    input  logic [63:0] res_high,
    input  logic        res_empty,
    output int          fail_count,
    output int          pending
);
    import iau_pkg::*;

    typedef struct {
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic               emp;
    } span_t;

    span_t want_q[$];

    assign pending = want_q.size();

    function automatic span_t span(logic signed [63:0] lo, logic signed [63:0] hi);
        span_t r;
        r.lo = lo;
        r.hi = hi;
        r.emp = 1'b0;
        return r;
    endfunction

    function automatic span_t full_span();
        return span(S64_MIN, S64_MAX);
    endfunction

    // exact product through 128 bits; ovf set when it does not fit 64 signed
    function automatic logic signed [63:0] prod(logic signed [63:0] x,
                                                logic signed [63:0] y,
                                                inout logic ovf);
        logic signed [127:0] p;
        p = 128'(x) * 128'(y);
        if (p > 128'sd9223372036854775807 || p < -128'sd9223372036854775808)
            ovf = 1'b1;
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] smin(logic signed [63:0] x, logic signed [63:0] y);
        return x < y ? x : y;
    endfunction

    function automatic logic signed [63:0] smax(logic signed [63:0] x, logic signed [63:0] y);
        return x > y ? x : y;
    endfunction

    function automatic logic signed [63:0] ones_cover(logic [63:0] m);
        logic [63:0] r;
        r = 0;
        for (int i = 0; i < 64; i++)
            if (m[i]) r = (i == 63) ? S64_MAX : ((64'd1 << (i + 1)) - 1);
        return r;
    endfunction

    function automatic span_t predict_interval(logic [3:0] op, span_t a, span_t b, span_t c);
        logic signed [64:0] s1, s2;
        logic signed [63:0] p1, p2, p3, p4, k;
        logic ovf;
        bit ac, bc;
        span_t r;
        ac = a.lo == a.hi;
        bc = b.lo == b.hi;
        ovf = 0;
        r = full_span();
        if (op <= OP_ASHR && (a.emp || b.emp)) r.emp = 1;
        else if (op >= OP_ZEXT && op <= OP_TRUNC && a.emp) r.emp = 1;
        else if (op == OP_SELECT && (a.emp || b.emp || c.emp)) r.emp = 1;
        else case (op)
            OP_ADD, OP_SUB: begin
                s1 = (op == OP_ADD) ? 65'(a.lo) + 65'(b.lo) : 65'(a.lo) - 65'(b.hi);
                s2 = (op == OP_ADD) ? 65'(a.hi) + 65'(b.hi) : 65'(a.hi) - 65'(b.lo);
                if (s1[64] == s1[63] && s2[64] == s2[63]) r = span(s1[63:0], s2[63:0]);
            end
            OP_MUL: begin
                p1 = prod(a.lo, b.lo, ovf);
                p2 = prod(a.lo, b.hi, ovf);
                p3 = prod(a.hi, b.lo, ovf);
                p4 = prod(a.hi, b.hi, ovf);
                if (!ovf) r = span(smin(smin(p1, p2), smin(p3, p4)),
                                   smax(smax(p1, p2), smax(p3, p4)));
            end
            OP_AND: begin
                if (ac && bc) r = span(a.lo & b.lo, a.lo & b.lo);
                else if (a.lo >= 0 && b.lo >= 0) r = span(0, smin(a.hi, b.hi));
                else if (a.lo >= 0) r = span(0, a.hi);
                else if (b.lo >= 0) r = span(0, b.hi);
            end
            OP_OR, OP_XOR: begin
                if (ac && bc) begin
                    k = (op == OP_OR) ? (a.lo | b.lo) : (a.lo ^ b.lo);
                    r = span(k, k);
                end else if (a.lo >= 0 && b.lo >= 0) begin
                    k = a.hi | b.hi;
                    if (k == 0) r = span(0, 0);
                    else r = span(op == OP_OR ? smax(a.lo, b.lo) : 0, ones_cover(k));
                end
            end
            OP_SHL: begin
                if (bc && b.lo >= 0 && b.lo < 63) begin
                    k = 64'sd1 <<< b.lo[5:0];
                    p1 = prod(a.lo, k, ovf);
                    p2 = prod(a.hi, k, ovf);
                    if (!ovf) r = span(smin(p1, p2), smax(p1, p2));
                end
            end
            OP_LSHR: begin
                if (bc && b.lo == 64) r = span(0, 0);
                else if (bc && b.lo >= 0 && b.lo < 64 && a.lo >= 0)
                    r = span(a.lo >>> b.lo[5:0], a.hi >>> b.lo[5:0]);
            end
            OP_ASHR: begin
                if (bc && b.lo >= 0 && b.lo < 64)
                    r = span(a.lo >>> b.lo[5:0], a.hi >>> b.lo[5:0]);
            end
            OP_ZEXT: begin
                if (a.lo >= 0 && a.hi <= $signed(U32_MAX)) r = a;
                else r = span(0, U32_MAX);
            end
            OP_SEXT: begin
                p1 = smax($signed(S32_MIN), a.lo);
                p2 = smin($signed(S32_MAX), a.hi);
                r = (p1 > p2) ? span(S32_MIN, S32_MAX) : span(p1, p2);
            end
            OP_TRUNC: begin
                if (a.lo >= $signed(S32_MIN) && a.hi <= $signed(S32_MAX)) r = a;
                else r = span(S32_MIN, S32_MAX);
            end
            OP_SELECT: begin
                if (ac) r = (a.lo != 0) ? b : c;
                else r = span(smin(b.lo, c.lo), smax(b.hi, c.hi));
            end
            default: r = full_span();
        endcase
        if (r.emp) begin
            r.lo = 0;
            r.hi = 0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        span_t a, b, c, want;
        if (!rst_n) begin
            fail_count <= 0;
        end
        else begin
            if (in_valid && in_ready) begin
                a = '{a_low, a_high, a_empty};
                b = '{b_low, b_high, b_empty};
                c = '{c_low, c_high, c_empty};
                want_q.push_back(predict_interval(action, a, b, c));
            end
            if (out_valid && out_ready) begin
                if (want_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result word at %0t", $time);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = want_q.pop_front();
                    if (want.lo !== res_low || want.hi !== res_high
                        || want.emp !== res_empty) begin
                        if (fail_count < 10)
                            $display("mismatch: exp %0d %0d %b got %0d %0d %b",
                                     want.lo, want.hi, want.emp,
                                     $signed(res_low), $signed(res_high), res_empty);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/tb_interval_arithmetic_unit_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interval arithmetic unit testbench
// Directed corner words, then random words with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_interval_arithmetic_unit_top;
    import iau_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS = 1350;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [3:0]  action = 0;
    logic [63:0] a_low = 0, a_high = 0, b_low = 0, b_high = 0, c_low = 0, c_high = 0;
    logic        a_empty = 0, b_empty = 0, c_empty = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [63:0] res_low, res_high;
    logic        res_empty;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          sending_done = 0;

    always #5 clk = ~clk;

    interval_arithmetic_unit_top dut (.*);

    iau_checker checker_i (.*);

    // pick a bound value biased toward interesting corners
    function automatic logic [63:0] pick_bound();
        case ($urandom_range(0, 9))
            0: return S64_MAX;
            1: return S64_MIN;
            2: return 64'($signed($urandom_range(0, 8)) - 4);
            3: return 64'($urandom_range(0, 70));
            4: return {{32{1'b0}}, 32'($urandom)};
            5: return S32_MIN + 64'($urandom_range(0, 4)) - 2;
            6: return S32_MAX + 64'($urandom_range(0, 4)) - 2;
            7: return {32'($urandom), 32'($urandom)};
            8: return {{34{$urandom_range(0, 1) == 1}}, 30'($urandom)};
            default: return 64'($signed(16'($urandom)));
        endcase
    endfunction

    // valid stays high across back-to-back words; it drops only for a gap
    task automatic send_word(logic [3:0] op, logic [63:0] al, logic [63:0] ah, logic ae,
                             logic [63:0] bl, logic [63:0] bh, logic be,
                             logic [63:0] cl, logic [63:0] ch, logic ce);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        action <= op;
        a_low <= al; a_high <= ah; a_empty <= ae;
        b_low <= bl; b_high <= bh; b_empty <= be;
        c_low <= cl; c_high <= ch; c_empty <= ce;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random();
        logic [63:0] al, ah, bl, bh, cl, ch;
        logic [3:0] op;
        al = pick_bound(); ah = pick_bound();
        bl = pick_bound(); bh = pick_bound();
        cl = pick_bound(); ch = pick_bound();
        op = 4'($urandom_range(0, 15));
        // mostly ordered, frequently constant operands
        if ($urandom_range(0, 7) != 0 && $signed(al) > $signed(ah)) {al, ah} = {ah, al};
        if ($urandom_range(0, 7) != 0 && $signed(bl) > $signed(bh)) {bl, bh} = {bh, bl};
        if ($urandom_range(0, 7) != 0 && $signed(cl) > $signed(ch)) {cl, ch} = {ch, cl};
        if ($urandom_range(0, 2) == 0) ah = al;
        if ($urandom_range(0, 2) == 0) bh = bl;
        if ((op == OP_SHL || op == OP_LSHR || op == OP_ASHR) && $urandom_range(0, 3) != 0)
        begin
            bl = 64'($urandom_range(0, 66));
            bh = bl;
        end
        send_word(op, al, ah, $urandom_range(0, 9) == 0, bl, bh, $urandom_range(0, 9) == 0,
                  cl, ch, $urandom_range(0, 9) == 0);
    endtask

    // result side stalls at random, with calm stretches of always-ready
    initial begin
        int stall;
        forever begin
            @(posedge clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                out_ready <= 0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1;
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    // watchdog: cycles with no word moved on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !sending_done) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: every op at the extremes and special cases
        send_word(OP_ADD, S64_MAX, S64_MAX, 0, 1, 1, 0, 0, 0, 0);
        send_word(OP_SUB, S64_MIN, 0, 0, 1, 1, 0, 0, 0, 0);
        send_word(OP_SUB, 5, 9, 0, -3, 2, 0, 0, 0, 0);
        send_word(OP_MUL, S64_MIN, S64_MIN, 0, -1, -1, 0, 0, 0, 0);
        send_word(OP_MUL, S64_MIN, 3, 0, 1, 1, 0, 0, 0, 0);
        send_word(OP_AND, 12, 12, 0, 10, 10, 0, 0, 0, 0);
        send_word(OP_AND, -5, 4, 0, 3, 7, 0, 0, 0, 0);
        send_word(OP_OR, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        send_word(OP_OR, 2, S64_MAX, 0, 1, 9, 0, 0, 0, 0);
        send_word(OP_XOR, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        send_word(OP_SHL, 1, 1, 0, 62, 62, 0, 0, 0, 0);
        send_word(OP_SHL, 1, 1, 0, 63, 63, 0, 0, 0, 0);
        send_word(OP_LSHR, -8, 8, 0, 64, 64, 0, 0, 0, 0);
        send_word(OP_LSHR, -8, 8, 0, 1, 1, 0, 0, 0, 0);
        send_word(OP_LSHR, 0, S64_MAX, 0, 65, 65, 0, 0, 0, 0);
        send_word(OP_ASHR, S64_MIN, -1, 0, 63, 63, 0, 0, 0, 0);
        send_word(OP_ZEXT, 0, U32_MAX, 0, 0, 0, 1, 0, 0, 1);
        send_word(OP_SEXT, S64_MIN, S64_MIN, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_TRUNC, S32_MIN, S32_MAX, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_TRUNC, 9, 3, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_SELECT, 0, 0, 0, 1, 2, 0, 7, 8, 0);
        send_word(OP_SELECT, 0, 1, 0, -1, 2, 0, 7, 8, 0);
        send_word(OP_SELECT, 1, 1, 0, 1, 2, 0, 7, 8, 1);
        send_word(4'd13, 0, 0, 1, 0, 0, 1, 0, 0, 1);
        send_word(4'd15, -1, -1, 0, -1, -1, 0, -1, -1, 0);
        in_valid <= 0;
        // hold off until the pipe drains
        while (pending != 0) @(posedge clk);
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            // bursts with no sender gap ride on the random gap draw of zero
            send_random();
        end
        in_valid <= 0;
        sending_done = 1;
        for (int i = 0; i < 20000 && pending != 0; i++) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[interval_arithmetic_unit_top.f]
+incdir+rtl
rtl/iau_pkg.sv
rtl/iau_front.sv
rtl/iau_queue.sv
rtl/iau_back.sv
rtl/interval_arithmetic_unit_top.sv
rtl/iau_checker.sv
sim/iau_checker.sv
sim/tb_interval_arithmetic_unit_top.sv
